FILE: rtl/core/csfs_pkg.sv
// ============================================================================
// csfs_pkg - shared types, codes and IEEE single helpers
// Types, codes and round-to-nearest-even float arithmetic for the field sum.
// ============================================================================
package csfs_pkg;

    localparam int MAX_SEGMENTS_DEF = 1024;

    localparam logic       FUNC_LOAD  = 1'b0;
    localparam logic       FUNC_QUERY = 1'b1;

    localparam logic [1:0] COMP_HX   = 2'd0;
    localparam logic [1:0] COMP_HY   = 2'd1;
    localparam logic [1:0] COMP_HZ   = 2'd2;
    localparam logic [1:0] COMP_NONE = 2'd3;

    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] QNAN_POS     = 32'h7FC0_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
    localparam logic [30:0] INF_MAG      = 31'h7F80_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_FETCH,
        ST_OPS,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_SQRT_FIN,
        ST_RECIP_INIT,
        ST_RECIP,
        ST_RECIP_FIN,
        ST_CALC,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } alu_op_t;

    // Leading zero count of a nonzero 50-bit word.
    function automatic logic [5:0] lzc50(input logic [49:0] m);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (m[i]) n = 6'(49 - i);
        end
        return n;
    endfunction

    // Value is m * 2^(e - 176); m nonzero. Normalize, round to nearest even, pack.
    function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                               input logic [49:0] m);
        logic [5:0]         lz;
        logic [49:0]        mn;
        logic signed [11:0] en;
        logic [26:0]        m27;
        logic [26:0]        msk;
        logic [4:0]         sh;
        logic [7:0]         ef;
        logic               up;
        logic [31:0]        mag;
        lz  = lzc50(m);
        mn  = m << lz;
        en  = e - 12'(lz);
        m27 = {mn[49:24], |mn[23:0]};
        if (en <= 12'sd0) begin
            if (en < -12'sd26) sh = 5'd27;
            else               sh = 5'(12'sd1 - en);
            msk = ~(27'h7FF_FFFF << sh);
            m27 = (m27 >> sh) | {26'b0, |(m27 & msk)};
            ef  = 8'd0;
        end else if (en >= 12'sd255) begin
            ef = 8'hFF;
        end else begin
            ef = en[7:0];
        end
        up = m27[2] & (m27[3] | m27[1] | m27[0]);
        if (ef == 8'hFF) begin
            mag = {1'b0, INF_MAG};
        end else begin
            mag = ((ef == 8'd0) ? 32'd0 : {1'b0, ef - 8'd1, 23'b0})
                + {8'b0, m27[26:3]} + {31'b0, up};
            if (mag >= {1'b0, INF_MAG}) mag = {1'b0, INF_MAG};
        end
        return {s, mag[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               na, nb, ia, ib, za, zb, s;
        logic [23:0]        ma, mb;
        logic [47:0]        p;
        logic signed [11:0] e;
        logic [31:0]        r;
        na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        za = (a[30:0] == 31'd0);
        zb = (b[30:0] == 31'd0);
        s  = a[31] ^ b[31];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        p  = 48'(ma) * 48'(mb);
        e  = 12'((a[30:23] == 8'd0) ? 8'd1 : a[30:23])
           + 12'((b[30:23] == 8'd0) ? 8'd1 : b[30:23]) - 12'sd126;
        if (na)                          r = a | QUIET_BIT;
        else if (nb)                     r = b | QUIET_BIT;
        else if ((ia && zb) || (za && ib)) r = QNAN_DEFAULT;
        else if (ia || ib)               r = {s, INF_MAG};
        else if (za || zb)               r = {s, 31'd0};
        else                             r = round_pack(s, e, {p, 2'b00});
        return r;
    endfunction

    // a + b, or a - b when neg is set.
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b,
                                           input logic neg);
        logic        na, nb, ia, ib, za, zb, swap;
        logic [31:0] bb, big, sml, r;
        logic [7:0]  eg, es, d;
        logic [23:0] mg, ms;
        logic [49:0] aa, b0, bs, rr, msk;
        bb   = b ^ {neg, 31'd0};
        na   = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nb   = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ia   = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        ib   = (bb[30:23] == 8'hFF) && (bb[22:0] == 23'd0);
        za   = (a[30:0] == 31'd0);
        zb   = (bb[30:0] == 31'd0);
        swap = bb[30:0] > a[30:0];
        big  = swap ? bb : a;
        sml  = swap ? a : bb;
        eg   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mg   = {big[30:23] != 8'd0, big[22:0]};
        ms   = {sml[30:23] != 8'd0, sml[22:0]};
        d    = eg - es;
        aa   = {1'b0, mg, 25'b0};
        b0   = {1'b0, ms, 25'b0};
        if (d >= 8'd50) begin
            bs = {49'b0, |b0};
        end else begin
            msk = ~(50'h3_FFFF_FFFF_FFFF << d);
            bs  = (b0 >> d) | {49'b0, |(b0 & msk)};
        end
        rr = (big[31] == sml[31]) ? (aa + bs) : (aa - bs);
        if (na)                                r = a | QUIET_BIT;
        else if (nb)                           r = b | QUIET_BIT;
        else if (ia && ib && (a[31] != bb[31])) r = QNAN_DEFAULT;
        else if (ia)                           r = a;
        else if (ib)                           r = bb;
        else if (za && zb)                     r = {a[31] & bb[31], 31'd0};
        else if (rr == 50'd0)                  r = 32'd0;
        else                                   r = round_pack(big[31], 12'(eg) + 12'sd1, rr);
        return r;
    endfunction

endpackage

FILE: rtl/core/current_segment_field_sum.sv
// ============================================================================
// current_segment_field_sum - planar current element field sum
// Holds a table of current elements in one memory and sums the Biot-Savart
// contribution of each stored element at an observation point.
// ============================================================================
//
//  channel   direction  transfer when        payload
//  -------   ---------  -------------------  ---------------------------------
//  cfg       in         cfg_wr_en            cfg_wr_data = segment_count
//  s_        in         s_valid & s_ready    func, element or query fields
//  m_        out        m_valid & m_ready    field_value
//
//  A load with an index below MAX_SEGMENTS writes its slot at the transfer edge.
//  A query does, for each of its n summed elements, one memory read, six
//  add/mul steps, a 26-step square root, a 27-step reciprocal and thirteen
//  add/mul steps; the add/mul steps go through one shared float unit.
//  An element whose squared distance is zero or not finite skips the root
//  steps, and one whose length is zero or not finite skips the reciprocal.
//  Reset clears the element count and the control state; the table is not
//  cleared. The finished value waits in the output register, so the next
//  item is taken while m_ready is low; a new result holds until it drains.
//
module current_segment_field_sum #(
    parameter int MAX_SEGMENTS = csfs_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [9:0]  s_elem_index,
    input  logic [31:0] s_elem_x,
    input  logic [31:0] s_elem_y,
    input  logic [31:0] s_current_x,
    input  logic [31:0] s_current_y,
    input  logic [31:0] s_obs_x,
    input  logic [31:0] s_obs_y,
    input  logic [31:0] s_obs_z,
    input  logic [1:0]  s_component,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_field_value
);
    import csfs_pkg::*;

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    // element table: {x, y, ix, iy}
    logic [127:0] mem [MAX_SEGMENTS];
    logic [127:0] rd_data_reg;
    logic         mem_wr_en;
    logic         mem_rd_en;
    logic [AW-1:0] wr_addr;

    state_t state_reg, state_next;

    logic [10:0]  seg_count_reg;
    logic [CW-1:0] n_reg, idx_reg;
    logic [3:0]   op_cnt_reg;
    logic [1:0]   comp_reg;
    logic [31:0]  px_reg, py_reg, pz_reg, sz_reg;
    logic [31:0]  rx_reg, ry_reg, sx_reg, sy_reg, s3_reg;
    logic [31:0]  len_reg, inv_reg, k_reg, tmp_reg, tmp2_reg;
    logic [31:0]  h1_reg, h2_reg, h3_reg;
    logic         m_valid_reg;
    logic [31:0]  m_value_reg;

    // square root iteration
    logic [50:0]       sq_v_reg, sq_res_reg, sq_bit_reg;
    logic signed [9:0] sq_e_reg;

    // reciprocal iteration
    logic [23:0]        rc_mx_reg;
    logic [24:0]        rc_rem_reg;
    logic [26:0]        rc_q_reg;
    logic [4:0]         rc_cnt_reg;
    logic signed [11:0] rc_e_reg;

    alu_op_t     alu_op;
    logic [31:0] alu_a, alu_b, alu_res;

    logic [31:0] eix, eiy, ex_pos, ey_pos;
    logic        last_elem;
    logic        out_load;

    // square root setup
    logic [23:0]       sq_m24, sq_mant;
    logic [5:0]        sq_lz;
    logic signed [9:0] sq_e0;
    logic [24:0]       sq_mant25;
    logic              sq_special;
    logic [31:0]       sq_special_val;
    logic [50:0]       sq_t;
    logic [49:0]       sq_m;
    logic              sq_up;
    logic signed [9:0] sq_eh;
    logic [31:0]       sq_len;

    // reciprocal setup
    logic [23:0]       rc_m24;
    logic [5:0]        rc_lz;
    logic              rc_special;
    logic [31:0]       rc_special_val;

    logic [31:0] count_lim;

    assign ex_pos = rd_data_reg[127:96];
    assign ey_pos = rd_data_reg[95:64];
    assign eix    = rd_data_reg[63:32];
    assign eiy    = rd_data_reg[31:0];

    assign last_elem = (idx_reg + CW'(1)) == n_reg;
    assign wr_addr   = AW'(s_elem_index);
    assign count_lim = (32'(seg_count_reg) > 32'(MAX_SEGMENTS)) ? 32'(MAX_SEGMENTS)
                                                                 : 32'(seg_count_reg);

    // ------------------------------------------------------------------
    // Shared float unit
    // ------------------------------------------------------------------
    assign alu_res = (alu_op == ALU_MUL) ? fp_mul(alu_a, alu_b)
                                         : fp_add(alu_a, alu_b, alu_op == ALU_SUB);

    // ------------------------------------------------------------------
    // Square root: special inputs, then digit recurrence on the mantissa
    // ------------------------------------------------------------------
    always_comb begin
        sq_m24 = {s3_reg[30:23] != 8'd0, s3_reg[22:0]};
        sq_lz  = lzc50({sq_m24, 26'b0});
        sq_mant = sq_m24 << sq_lz;
        sq_e0  = ((s3_reg[30:23] == 8'd0) ? -10'sd126 : (10'(s3_reg[30:23]) - 10'sd127))
               - 10'(sq_lz);
        if (sq_e0[0]) begin
            sq_e0     = sq_e0 - 10'sd1;
            sq_mant25 = {sq_mant, 1'b0};
        end else begin
            sq_mant25 = {1'b0, sq_mant};
        end
        sq_special     = 1'b1;
        sq_special_val = s3_reg;
        if (s3_reg[30:23] == 8'hFF) begin
            if (s3_reg[22:0] != 23'd0) sq_special_val = s3_reg | QUIET_BIT;
            else if (s3_reg[31])       sq_special_val = QNAN_POS;
        end else if (s3_reg[30:0] == 31'd0) begin
            sq_special_val = s3_reg;
        end else if (s3_reg[31]) begin
            sq_special_val = QNAN_POS;
        end else begin
            sq_special = 1'b0;
        end
    end

    always_comb begin
        sq_t  = sq_res_reg + sq_bit_reg;
        sq_m  = sq_res_reg[50:1];
        sq_up = sq_res_reg[0] && ((sq_v_reg != 51'd0) || sq_m[0]);
        sq_m  = sq_m + 50'(sq_up);
        sq_eh = (sq_e_reg >>> 1);
        if (sq_m == 50'h100_0000) begin
            sq_m  = sq_m >> 1;
            sq_eh = sq_eh + 10'sd1;
        end
        sq_len = {1'b0, 8'(sq_eh + 10'sd127), sq_m[22:0]};
    end

    // ------------------------------------------------------------------
    // Reciprocal setup
    // ------------------------------------------------------------------
    always_comb begin
        rc_m24 = {len_reg[30:23] != 8'd0, len_reg[22:0]};
        rc_lz  = lzc50({rc_m24, 26'b0});
        rc_special = 1'b1;
        if (len_reg[30:23] == 8'hFF && len_reg[22:0] != 23'd0)
            rc_special_val = len_reg | QUIET_BIT;
        else if (len_reg[30:23] == 8'hFF)
            rc_special_val = {len_reg[31], 31'd0};
        else if (len_reg[30:0] == 31'd0)
            rc_special_val = {len_reg[31], INF_MAG};
        else begin
            rc_special_val = 32'd0;
            rc_special     = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_func == FUNC_QUERY && s_component != COMP_NONE)
                    state_next = ST_START;
            end
            ST_START: begin
                state_next = (n_reg == CW'(0)) ? ST_OUT : ST_FETCH;
            end
            ST_FETCH: state_next = ST_OPS;
            ST_OPS: begin
                if (op_cnt_reg == 4'd5) state_next = ST_SQRT_INIT;
            end
            ST_SQRT_INIT: state_next = sq_special ? ST_RECIP_INIT : ST_SQRT;
            ST_SQRT: begin
                if (sq_bit_reg == 51'd1) state_next = ST_SQRT_FIN;
            end
            ST_SQRT_FIN:   state_next = ST_RECIP_INIT;
            ST_RECIP_INIT: state_next = rc_special ? ST_CALC : ST_RECIP;
            ST_RECIP: begin
                if (rc_cnt_reg == 5'd26) state_next = ST_RECIP_FIN;
            end
            ST_RECIP_FIN: state_next = ST_CALC;
            ST_CALC: begin
                if (op_cnt_reg == 4'd12) state_next = last_elem ? ST_OUT : ST_FETCH;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs and float unit operand select
    // ------------------------------------------------------------------
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        mem_wr_en = 1'b0;
        mem_rd_en = (state_reg == ST_FETCH);
        out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
        alu_op    = ALU_MUL;
        alu_a     = pz_reg;
        alu_b     = pz_reg;
        if (state_reg == ST_IDLE && s_valid && s_func == FUNC_LOAD
            && 32'(s_elem_index) < 32'(MAX_SEGMENTS))
            mem_wr_en = 1'b1;
        case (state_reg)
            ST_OPS: begin
                case (op_cnt_reg)
                    4'd0: begin alu_op = ALU_SUB; alu_a = px_reg; alu_b = ex_pos; end
                    4'd1: begin alu_op = ALU_SUB; alu_a = py_reg; alu_b = ey_pos; end
                    4'd2: begin alu_op = ALU_MUL; alu_a = rx_reg; alu_b = rx_reg; end
                    4'd3: begin alu_op = ALU_MUL; alu_a = ry_reg; alu_b = ry_reg; end
                    4'd4: begin alu_op = ALU_ADD; alu_a = sx_reg; alu_b = sy_reg; end
                    default: begin alu_op = ALU_ADD; alu_a = sx_reg; alu_b = sz_reg; end
                endcase
            end
            ST_CALC: begin
                case (op_cnt_reg)
                    4'd0: begin alu_op = ALU_MUL; alu_a = inv_reg; alu_b = inv_reg; end
                    4'd1: begin alu_op = ALU_MUL; alu_a = k_reg; alu_b = inv_reg; end
                    4'd2: begin alu_op = ALU_MUL; alu_a = eiy; alu_b = pz_reg; end
                    4'd3: begin alu_op = ALU_MUL; alu_a = tmp_reg; alu_b = k_reg; end
                    4'd4: begin alu_op = ALU_ADD; alu_a = h1_reg; alu_b = tmp_reg; end
                    4'd5: begin
                        alu_op = ALU_MUL; alu_a = eix ^ 32'h8000_0000; alu_b = pz_reg;
                    end
                    4'd6: begin alu_op = ALU_MUL; alu_a = tmp_reg; alu_b = k_reg; end
                    4'd7: begin alu_op = ALU_ADD; alu_a = h2_reg; alu_b = tmp_reg; end
                    4'd8: begin alu_op = ALU_MUL; alu_a = eix; alu_b = ry_reg; end
                    4'd9: begin alu_op = ALU_MUL; alu_a = eiy; alu_b = rx_reg; end
                    4'd10: begin alu_op = ALU_SUB; alu_a = tmp_reg; alu_b = tmp2_reg; end
                    4'd11: begin alu_op = ALU_MUL; alu_a = tmp_reg; alu_b = k_reg; end
                    default: begin alu_op = ALU_ADD; alu_a = h3_reg; alu_b = tmp_reg; end
                endcase
            end
            default: begin
                alu_op = ALU_MUL;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Element memory: one write port for loads, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            mem[wr_addr] <= {s_elem_x, s_elem_y, s_current_x, s_current_y};
        end
        if (mem_rd_en) begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            seg_count_reg <= 11'd0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) seg_count_reg <= cfg_wr_data;
            // hold the result until its transfer; load a new one behind it
            if (out_load)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                px_reg   <= s_obs_x;
                py_reg   <= s_obs_y;
                pz_reg   <= s_obs_z;
                comp_reg <= s_component;
                h1_reg   <= 32'd0;
                h2_reg   <= 32'd0;
                h3_reg   <= 32'd0;
                idx_reg  <= CW'(0);
                n_reg    <= CW'(count_lim);
            end
            ST_START: begin
                sz_reg <= alu_res;
            end
            ST_FETCH: begin
                op_cnt_reg <= 4'd0;
            end
            ST_OPS: begin
                op_cnt_reg <= op_cnt_reg + 4'd1;
                case (op_cnt_reg)
                    4'd0: rx_reg <= alu_res;
                    4'd1: ry_reg <= alu_res;
                    4'd2: sx_reg <= alu_res;
                    4'd3: sy_reg <= alu_res;
                    4'd4: sx_reg <= alu_res;
                    default: s3_reg <= alu_res;
                endcase
            end
            ST_SQRT_INIT: begin
                len_reg    <= sq_special_val;
                sq_v_reg   <= {1'b0, sq_mant25, 25'b0};
                sq_res_reg <= 51'd0;
                sq_bit_reg <= 51'd1 << 50;
                sq_e_reg   <= sq_e0;
            end
            ST_SQRT: begin
                // one result bit per cycle
                if (sq_v_reg >= sq_t) begin
                    sq_v_reg   <= sq_v_reg - sq_t;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            ST_SQRT_FIN: begin
                len_reg <= sq_len;
            end
            ST_RECIP_INIT: begin
                inv_reg    <= rc_special_val;
                rc_mx_reg  <= rc_m24 << rc_lz;
                rc_e_reg   <= 12'sd254 - (12'((len_reg[30:23] == 8'd0) ? 8'd1 : len_reg[30:23])
                            - 12'(rc_lz));
                rc_rem_reg <= 25'h080_0000;
                rc_q_reg   <= 27'd0;
                rc_cnt_reg <= 5'd0;
                op_cnt_reg <= 4'd0;
            end
            ST_RECIP: begin
                // restoring division of 1.0 by the mantissa, one quotient bit a cycle
                if (rc_rem_reg >= 25'(rc_mx_reg)) begin
                    rc_q_reg   <= {rc_q_reg[25:0], 1'b1};
                    rc_rem_reg <= (rc_rem_reg - 25'(rc_mx_reg)) << 1;
                end else begin
                    rc_q_reg   <= {rc_q_reg[25:0], 1'b0};
                    rc_rem_reg <= rc_rem_reg << 1;
                end
                rc_cnt_reg <= rc_cnt_reg + 5'd1;
            end
            ST_RECIP_FIN: begin
                inv_reg <= round_pack(len_reg[31], rc_e_reg,
                                      {rc_q_reg, rc_rem_reg != 25'd0, 22'b0});
            end
            ST_CALC: begin
                op_cnt_reg <= op_cnt_reg + 4'd1;
                case (op_cnt_reg)
                    4'd0: k_reg  <= alu_res;
                    4'd1: k_reg  <= alu_res;
                    4'd4: h1_reg <= alu_res;
                    4'd7: h2_reg <= alu_res;
                    4'd9: tmp2_reg <= alu_res;
                    4'd12: begin
                        h3_reg  <= alu_res;
                        idx_reg <= idx_reg + CW'(1);
                    end
                    default: tmp_reg <= alu_res;
                endcase
            end
            ST_OUT: begin
                if (out_load) begin
                    case (comp_reg)
                        COMP_HX: m_value_reg <= h1_reg;
                        COMP_HY: m_value_reg <= h2_reg;
                        default: m_value_reg <= h3_reg;
                    endcase
                end
            end
            default: begin
                op_cnt_reg <= op_cnt_reg;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_field_value = m_value_reg;

endmodule
